// ----- sv/rsd_pkg.sv -----
// ----------------------------------------------------------------------------
// rsd_pkg: shared types and constants of the rounding saturating divider
// Holds the mode codes, the result patterns used for saturation and the
// record that travels down the divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rsd_pkg;

  localparam int unsigned DataW = 32;

  // Operand kinds: dividend/divisor -> result.
  localparam logic [2:0] MODE_SSS = 3'd0;
  localparam logic [2:0] MODE_SUS = 3'd1;
  localparam logic [2:0] MODE_USS = 3'd2;
  localparam logic [2:0] MODE_SSU = 3'd3;
  localparam logic [2:0] MODE_SUU = 3'd4;
  localparam logic [2:0] MODE_UUU = 3'd5;

  localparam logic [DataW-1:0] SMAX_PAT = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] SMIN_PAT = 32'h8000_0000;
  localparam logic [DataW-1:0] UMAX_PAT = 32'hFFFF_FFFF;
  localparam logic [DataW-1:0] ZERO_PAT = 32'h0000_0000;

  // One item in flight through the divider.
  typedef struct packed {
    logic             valid;
    logic [DataW-1:0] rem;       // partial remainder
    logic [DataW-1:0] num;       // dividend bits left, quotient bits enter at the bottom
    logic [DataW-1:0] den;       // divisor magnitude
    logic             special;   // result is fixed, division is ignored
    logic [DataW-1:0] spec_val;
    logic             neg;       // negate the rounded magnitude
    logic             sat;       // clamp a magnitude above signed max
  } div_t;

endpackage

`default_nettype wire

// ----- sv/rsd_prep.sv -----
// ----------------------------------------------------------------------------
// rsd_prep: operand preparation stage
// Decodes the mode, takes operand magnitudes, and flags the cases whose
// result is fixed (divide by zero, overflow, negative unsigned result, unknown mode).
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_prep (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      valid_i,
  input  wire logic [2:0]                mode_i,
  input  wire logic [rsd_pkg::DataW-1:0] dividend_i,
  input  wire logic [rsd_pkg::DataW-1:0] divisor_i,
  output rsd_pkg::div_t                  stage_o
);
  import rsd_pkg::*;

  div_t             stage_d, stage_q;
  logic             xneg, yneg, yzero, yones;
  logic [DataW-1:0] xmag, ymag;

  assign xneg  = dividend_i[DataW-1];
  assign yneg  = divisor_i[DataW-1];
  assign yzero = (divisor_i == ZERO_PAT);
  assign yones = (divisor_i == UMAX_PAT);
  assign xmag  = xneg ? (ZERO_PAT - dividend_i) : dividend_i;
  assign ymag  = yneg ? (ZERO_PAT - divisor_i) : divisor_i;

  // Mode decode into operands and post-processing flags.
  always_comb begin
    stage_d          = '0;
    stage_d.valid    = valid_i;
    stage_d.rem      = ZERO_PAT;
    stage_d.num      = dividend_i;
    stage_d.den      = divisor_i;
    unique case (mode_i)
      MODE_SSS: begin
        stage_d.num = xmag;
        stage_d.den = ymag;
        stage_d.neg = xneg ^ yneg;
        if (yzero) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = xneg ? SMIN_PAT : SMAX_PAT;
        end else if (dividend_i == SMIN_PAT && yones) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = SMAX_PAT;
        end
      end
      MODE_SUS: begin
        stage_d.num = xmag;
        stage_d.neg = xneg;
        if (yzero) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = xneg ? SMIN_PAT : SMAX_PAT;
        end
      end
      MODE_USS: begin
        stage_d.den = ymag;
        stage_d.neg = yneg;
        stage_d.sat = !yneg;
        if (yzero) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = SMAX_PAT;
        end else if (xneg && yones) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = SMIN_PAT;
        end
      end
      MODE_SSU: begin
        stage_d.num = xmag;
        stage_d.den = ymag;
        if (yzero) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = xneg ? ZERO_PAT : UMAX_PAT;
        end else if (xneg != yneg && !(dividend_i == ZERO_PAT && yneg)) begin
          // A negative true quotient has no unsigned result.
          stage_d.special  = 1'b1;
          stage_d.spec_val = ZERO_PAT;
        end
      end
      MODE_SUU: begin
        if (yzero) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = xneg ? ZERO_PAT : UMAX_PAT;
        end else if (xneg) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = ZERO_PAT;
        end
      end
      MODE_UUU: begin
        if (yzero) begin
          stage_d.special  = 1'b1;
          stage_d.spec_val = UMAX_PAT;
        end
      end
      default: begin
        stage_d.special  = 1'b1;
        stage_d.spec_val = ZERO_PAT;
      end
    endcase
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- sv/rsd_div_stage.sv -----
// ----------------------------------------------------------------------------
// rsd_div_stage: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits, and records the quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_div_stage (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire rsd_pkg::div_t stage_i,
  output rsd_pkg::div_t stage_o
);
  import rsd_pkg::*;

  div_t           stage_d, stage_q;
  logic [DataW:0] trial, diff;
  logic           take;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {stage_i.rem, stage_i.num[DataW-1]};
  assign diff  = trial - {1'b0, stage_i.den};
  assign take  = !diff[DataW];

  always_comb begin
    stage_d     = stage_i;
    stage_d.rem = take ? diff[DataW-1:0] : trial[DataW-1:0];
    stage_d.num = {stage_i.num[DataW-2:0], take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q.valid <= 1'b0;
    end else if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ----- sv/rsd_post.sv -----
// ----------------------------------------------------------------------------
// rsd_post: rounding and saturation stage
// Rounds the quotient half away from zero, applies the sign, clamps and
// substitutes fixed results, and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsd_post (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire rsd_pkg::div_t             stage_i,
  output logic                           valid_o,
  output logic [rsd_pkg::DataW-1:0]      quotient_o
);
  import rsd_pkg::*;

  logic             round_up;
  logic [DataW-1:0] q_rnd, q_neg, q_d, q_q;
  logic             valid_q;

  // Twice the remainder against the divisor decides the round-up.
  assign round_up = ({stage_i.rem, 1'b0} >= {1'b0, stage_i.den});
  assign q_rnd    = stage_i.num + {{(DataW-1){1'b0}}, round_up};
  // The negated rounded value is ~num + 1 - round_up, so one adder suffices.
  assign q_neg    = ~stage_i.num + {{(DataW-1){1'b0}}, !round_up};

  always_comb begin
    if (stage_i.special) begin
      q_d = stage_i.spec_val;
    end else if (stage_i.neg) begin
      q_d = q_neg;
    end else if (stage_i.sat && q_rnd[DataW-1]) begin
      q_d = SMAX_PAT;
    end else begin
      q_d = q_rnd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= stage_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= q_d;
    end
  end

  assign valid_o    = valid_q;
  assign quotient_o = q_q;

endmodule

`default_nettype wire

// ----- sv/rounding_saturating_divider_32bit.sv -----
// An accepted input transaction passes one preparation stage, 32 restoring
// division stages and one rounding stage on its way to the result.
// Throughput: one transaction per cycle; the 32-stage divider chain is fully
// pipelined and advances as a whole unless a waiting result is stalled.
// Reset clears all pipeline valid bits; no result is pending after reset.
// ----------------------------------------------------------------------------
// rounding_saturating_divider_32bit: pipelined rounding saturating divider
// Signed and unsigned 32-bit division with round half away from zero and
// saturation of divide by zero, overflow and out-of-range results.
// ----------------------------------------------------------------------------
`default_nettype none

module rounding_saturating_divider_32bit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  output logic                           stall_o,
  input  wire logic [2:0]                mode_i,
  input  wire logic [rsd_pkg::DataW-1:0] dividend_i,
  input  wire logic [rsd_pkg::DataW-1:0] divisor_i,
  output logic                           valid_o,
  input  wire logic                      stall_i,
  output logic [rsd_pkg::DataW-1:0]      quotient_o
);
  import rsd_pkg::*;

  div_t pipe [DataW+1];
  logic en;

  // The whole pipeline holds while a finished result is stalled.
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  rsd_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (valid_i),
    .mode_i     (mode_i),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .stage_o    (pipe[0])
  );

  // One quotient bit per stage, most significant first.
  for (genvar i = 0; i < DataW; i++) begin : g_div
    rsd_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .stage_i (pipe[i]),
      .stage_o (pipe[i+1])
    );
  end

  rsd_post u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .stage_i    (pipe[DataW]),
    .valid_o    (valid_o),
    .quotient_o (quotient_o)
  );

endmodule

`default_nettype wire
